// ===== src/wss_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed sample statistics package
// Shared widths, datapath operation codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned NumChan   = 8;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CountW    = 17;
  localparam int unsigned SumW      = 33;
  localparam int unsigned SqSumW    = 47;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned DivW      = 32;
  localparam int unsigned UsedW     = 4;
  localparam int unsigned IterW     = 5;

  localparam logic [CountW-1:0] MaxWindow = 17'd65536;
  localparam logic [UsedW-1:0]  MaxUsed   = 4'd8;
  localparam logic signed [SampleW-1:0] SamplePosMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleNegMin = 16'sh8000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_UPD,
    OP_SQ,
    OP_P0,
    OP_P1,
    OP_VAR,
    OP_ROOT,
    OP_DIVM_LD,
    OP_DIV,
    OP_DIVS_LD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_use;
    logic close;
    logic out_busy;
  } status_t;

endpackage

// ===== src/wss_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed sample statistics controller
// Sequences load, update, multiply, variance, root, divide and output steps of the datapath.
// ---------------------------------------------------------------------------
module wss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wss_pkg::status_t status_i,
  output wss_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPD    = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_P0     = 4'd3;
  localparam logic [3:0] S_P1     = 4'd4;
  localparam logic [3:0] S_VAR    = 4'd5;
  localparam logic [3:0] S_ROOT   = 4'd6;
  localparam logic [3:0] S_DVM_LD = 4'd7;
  localparam logic [3:0] S_DVM    = 4'd8;
  localparam logic [3:0] S_DVS_LD = 4'd9;
  localparam logic [3:0] S_DVS    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]                  state_q, state_d;
  logic [wss_pkg::IterW-1:0]   cnt_q, cnt_d;
  logic                        last_iter;

  assign last_iter  = (cnt_q == '1);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = wss_pkg::OP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = wss_pkg::OP_LOAD;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.op = wss_pkg::OP_UPD;
        state_d  = (status_i.in_use && status_i.close) ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd_o.op = wss_pkg::OP_SQ;
        state_d  = S_P0;
      end
      S_P0: begin
        cmd_o.op = wss_pkg::OP_P0;
        state_d  = S_P1;
      end
      S_P1: begin
        cmd_o.op = wss_pkg::OP_P1;
        state_d  = S_VAR;
      end
      S_VAR: begin
        cmd_o.op = wss_pkg::OP_VAR;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = wss_pkg::OP_ROOT;
        cnt_d    = cnt_q + 1'b1;
        if (last_iter) state_d = S_DVM_LD;
      end
      S_DVM_LD: begin
        cmd_o.op = wss_pkg::OP_DIVM_LD;
        state_d  = S_DVM;
      end
      S_DVM: begin
        cmd_o.op = wss_pkg::OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (last_iter) state_d = S_DVS_LD;
      end
      S_DVS_LD: begin
        cmd_o.op = wss_pkg::OP_DIVS_LD;
        state_d  = S_DVS;
      end
      S_DVS: begin
        cmd_o.op = wss_pkg::OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (last_iter) state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.op = wss_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/wss_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed sample statistics datapath
// Per-channel accumulators, shared multiplier steps, root and divide units.
// ---------------------------------------------------------------------------
module wss_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wss_pkg::cmd_t                       cmd_i,
  output wss_pkg::status_t                    status_o,
  input  logic [wss_pkg::CountW-1:0]          win_cfg_i,
  input  logic [wss_pkg::UsedW-1:0]           used_cfg_i,
  input  logic signed [wss_pkg::SampleW-1:0]  sample_i,
  input  logic [wss_pkg::ChanW-1:0]           chan_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wss_pkg::ChanW-1:0]           out_chan_o,
  output logic signed [wss_pkg::SampleW-1:0]  out_min_o,
  output logic signed [wss_pkg::SampleW-1:0]  out_max_o,
  output logic signed [wss_pkg::SampleW-1:0]  out_mean_o,
  output logic [wss_pkg::SampleW-1:0]         out_sd_o,
  output logic [wss_pkg::CountW-1:0]          out_count_o
);

  localparam int unsigned LoW = 24;

  // per-channel accumulators
  logic [wss_pkg::CountW-1:0]         cnt_q  [wss_pkg::NumChan];
  logic signed [wss_pkg::SumW-1:0]    sum_q  [wss_pkg::NumChan];
  logic [wss_pkg::SqSumW-1:0]         sq_q   [wss_pkg::NumChan];
  logic signed [wss_pkg::SampleW-1:0] min_q  [wss_pkg::NumChan];
  logic signed [wss_pkg::SampleW-1:0] max_q  [wss_pkg::NumChan];

  // latched input transaction
  logic signed [wss_pkg::SampleW-1:0] x_q;
  logic [wss_pkg::ChanW-1:0]          ch_q;
  logic                               last_q;

  // window snapshot and work registers
  logic [wss_pkg::ChanW-1:0]          w_ch_q;
  logic [wss_pkg::CountW-1:0]         w_n_q;
  logic signed [wss_pkg::SumW-1:0]    w_s1_q;
  logic [wss_pkg::SqSumW-1:0]         w_s2_q;
  logic signed [wss_pkg::SampleW-1:0] w_min_q, w_max_q, mean_q;
  logic [wss_pkg::ProdW-1:0]          sq1_q, prod_q, var_q;
  logic [wss_pkg::RootW-1:0]          root_q;
  logic [wss_pkg::RootW+1:0]          rrem_q;
  logic [wss_pkg::DivW-1:0]           dvd_q;
  logic [wss_pkg::CountW-1:0]         drem_q;
  logic                               out_valid_q;

  // update combinational
  logic [wss_pkg::CountW-1:0]         win_eff, new_cnt;
  logic [wss_pkg::UsedW-1:0]          used_eff;
  logic signed [wss_pkg::SumW-1:0]    new_sum;
  logic signed [2*wss_pkg::SampleW-1:0] x_sq;
  logic [wss_pkg::SqSumW-1:0]         new_sq;
  logic signed [wss_pkg::SampleW-1:0] new_min, new_max;
  logic [wss_pkg::SumW-1:0]           abs_s1;
  logic [wss_pkg::RootW+2:0]          r_shift, r_trial;
  logic [wss_pkg::CountW:0]           d_shift;
  logic [wss_pkg::CountW+LoW-1:0]     p_lo;
  logic [wss_pkg::CountW+wss_pkg::SqSumW-LoW-1:0] p_hi;

  always_comb begin
    win_eff = win_cfg_i;
    if (win_cfg_i == '0) win_eff = {{(wss_pkg::CountW-1){1'b0}}, 1'b1};
    if (win_cfg_i > wss_pkg::MaxWindow) win_eff = wss_pkg::MaxWindow;
    used_eff = used_cfg_i;
    if (used_cfg_i == '0) used_eff = {{(wss_pkg::UsedW-1){1'b0}}, 1'b1};
    if (used_cfg_i > wss_pkg::MaxUsed) used_eff = wss_pkg::MaxUsed;
  end

  assign new_cnt = cnt_q[ch_q] + 1'b1;
  assign new_sum = sum_q[ch_q] + wss_pkg::SumW'(x_q);
  assign x_sq    = x_q * x_q;
  assign new_sq  = sq_q[ch_q] + wss_pkg::SqSumW'(unsigned'(x_sq));
  assign new_min = (x_q < min_q[ch_q]) ? x_q : min_q[ch_q];
  assign new_max = (x_q > max_q[ch_q]) ? x_q : max_q[ch_q];

  assign status_o.in_use   = ({1'b0, ch_q} < used_eff);
  assign status_o.close    = (new_cnt >= win_eff) || last_q;
  assign status_o.out_busy = out_valid_q;

  assign abs_s1  = w_s1_q[wss_pkg::SumW-1] ? unsigned'(-w_s1_q) : unsigned'(w_s1_q);
  assign r_shift = {rrem_q[wss_pkg::RootW:0], var_q[wss_pkg::ProdW-1 -: 2]};
  assign r_trial = {1'b0, root_q, 2'b01};
  assign d_shift = {drem_q, dvd_q[wss_pkg::DivW-1]};

  // split n * S2 into two narrow partial products
  assign p_lo = w_n_q * w_s2_q[LoW-1:0];
  assign p_hi = w_n_q * w_s2_q[wss_pkg::SqSumW-1:LoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wss_pkg::NumChan; i++) begin
        cnt_q[i] <= '0;
        sum_q[i] <= '0;
        sq_q[i]  <= '0;
        min_q[i] <= wss_pkg::SamplePosMax;
        max_q[i] <= wss_pkg::SampleNegMin;
      end
    end else if (cmd_i.op == wss_pkg::OP_UPD && status_o.in_use) begin
      if (status_o.close) begin
        cnt_q[ch_q] <= '0;
        sum_q[ch_q] <= '0;
        sq_q[ch_q]  <= '0;
        min_q[ch_q] <= wss_pkg::SamplePosMax;
        max_q[ch_q] <= wss_pkg::SampleNegMin;
      end else begin
        cnt_q[ch_q] <= new_cnt;
        sum_q[ch_q] <= new_sum;
        sq_q[ch_q]  <= new_sq;
        min_q[ch_q] <= new_min;
        max_q[ch_q] <= new_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wss_pkg::OP_LOAD: begin
        x_q    <= sample_i;
        ch_q   <= chan_i;
        last_q <= last_i;
      end
      wss_pkg::OP_UPD: begin
        w_ch_q  <= ch_q;
        w_n_q   <= new_cnt;
        w_s1_q  <= new_sum;
        w_s2_q  <= new_sq;
        w_min_q <= new_min;
        w_max_q <= new_max;
      end
      wss_pkg::OP_SQ: begin
        sq1_q <= abs_s1[wss_pkg::DivW-1:0] * abs_s1[wss_pkg::DivW-1:0];
      end
      wss_pkg::OP_P0: begin
        prod_q <= wss_pkg::ProdW'(p_lo);
      end
      wss_pkg::OP_P1: begin
        prod_q <= prod_q + (wss_pkg::ProdW'(p_hi) << LoW);
      end
      wss_pkg::OP_VAR: begin
        var_q  <= (prod_q > sq1_q) ? (prod_q - sq1_q) : '0;
        root_q <= '0;
        rrem_q <= '0;
      end
      wss_pkg::OP_ROOT: begin
        var_q <= var_q << 2;
        if (r_shift >= r_trial) begin
          rrem_q <= (wss_pkg::RootW+2)'(r_shift - r_trial);
          root_q <= {root_q[wss_pkg::RootW-2:0], 1'b1};
        end else begin
          rrem_q <= (wss_pkg::RootW+2)'(r_shift);
          root_q <= {root_q[wss_pkg::RootW-2:0], 1'b0};
        end
      end
      wss_pkg::OP_DIVM_LD: begin
        dvd_q  <= abs_s1[wss_pkg::DivW-1:0];
        drem_q <= '0;
      end
      wss_pkg::OP_DIV: begin
        if (d_shift >= {1'b0, w_n_q}) begin
          drem_q <= wss_pkg::CountW'(d_shift - {1'b0, w_n_q});
          dvd_q  <= {dvd_q[wss_pkg::DivW-2:0], 1'b1};
        end else begin
          drem_q <= wss_pkg::CountW'(d_shift);
          dvd_q  <= {dvd_q[wss_pkg::DivW-2:0], 1'b0};
        end
      end
      wss_pkg::OP_DIVS_LD: begin
        mean_q <= w_s1_q[wss_pkg::SumW-1] ? -signed'(dvd_q[wss_pkg::SampleW-1:0])
                                          : signed'(dvd_q[wss_pkg::SampleW-1:0]);
        dvd_q  <= root_q;
        drem_q <= '0;
      end
      wss_pkg::OP_OUT: begin
        out_chan_o  <= w_ch_q;
        out_min_o   <= w_min_q;
        out_max_o   <= w_max_q;
        out_mean_o  <= mean_q;
        out_sd_o    <= dvd_q[wss_pkg::SampleW-1:0];
        out_count_o <= w_n_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == wss_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_out_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == wss_pkg::OP_OUT))
    else $error("result appeared without an output command");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == wss_pkg::OP_OUT) |-> !out_valid_q)
    else $error("output register overwritten while pending");

  a_cleared_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == wss_pkg::OP_UPD && status_o.in_use && status_o.close)
      |=> (cnt_q[$past(ch_q)] == '0))
    else $error("channel not cleared after window close");

endmodule

// ===== src/windowed_sample_statistics_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed sample statistics top level
// Per-channel min, max, mean and standard deviation over sample windows.
// ---------------------------------------------------------------------------
//  Port group  | Direction | Contents
//  s_*         | in        | tdata sample_value, tuser channel_index, tlast end_of_record
//  m_*         | out       | tuser out_channel, tdata min/max/mean/stddev/count
//  APB         | in/out    | reg 0 window_length at 0x0, reg 1 channels_in_use at 0x4
//
//  A sample that does not close a window goes through a latch step and an update step.
//  A window close adds three multiply steps, a variance step, a 32-step root
//  and two 32-step divides with their loads, then the output load.
//  A pending result stalls only the final load of the next closed window.
//  Reset clears all accumulators at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module windowed_sample_statistics_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_value
  input  logic [2:0]  s_tuser,   // [2:0] channel_index
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [15:0] min, [31:16] max, [47:32] mean,
                                 // [63:48] stddev, [80:64] count, rest zero
  output logic [2:0]  m_tuser,   // [2:0] out_channel
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_WIN  = 1'b0;
  localparam logic REG_USED = 1'b1;

  logic [wss_pkg::CountW-1:0] win_q;
  logic [wss_pkg::UsedW-1:0]  used_q;
  wss_pkg::cmd_t              cmd;
  wss_pkg::status_t           status;
  logic signed [15:0]         o_min, o_max, o_mean;
  logic [15:0]                o_sd;
  logic [16:0]                o_cnt;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= 17'd1024;
      used_q <= 4'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIN) win_q <= pwdata[wss_pkg::CountW-1:0];
      else                     used_q <= pwdata[wss_pkg::UsedW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_USED) ? {28'd0, used_q} : {15'd0, win_q};

  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .win_cfg_i   (win_q),
    .used_cfg_i  (used_q),
    .sample_i    (s_tdata),
    .chan_i      (s_tuser),
    .last_i      (s_tlast),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_chan_o  (m_tuser),
    .out_min_o   (o_min),
    .out_max_o   (o_max),
    .out_mean_o  (o_mean),
    .out_sd_o    (o_sd),
    .out_count_o (o_cnt)
  );

  assign m_tdata = {7'd0, o_cnt, o_sd, o_mean, o_max, o_min};

endmodule
